@@ hw/rtl/lhp_pkg.sv @@
// ----------------------------------------------------------------------------
// lhp_pkg
// Types and constants shared by the Laplacian high-pass filter modules.
// ----------------------------------------------------------------------------
package lhp_pkg;

  localparam int unsigned CFG_WIDTH_W  = 12;
  localparam int unsigned CFG_HEIGHT_W = 16;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  // floor(s / 3) == (s * 683) >> 11 for s <= 765
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned JOB_AW    = $clog2(JOB_DEPTH);
  localparam int unsigned JOB_CW    = $clog2(JOB_DEPTH + 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  filtered;
    logic [10:0] column;
    logic [15:0] row;
    logic        last_pixel;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  centre;
    logic [7:0]  north;
    logic [7:0]  south;
    logic [7:0]  west;
    logic [7:0]  east;
    logic [10:0] column;
    logic [15:0] row;
    logic        last_pixel;
  } lhp_job_t;

endpackage

@@ hw/rtl/laplacian_highpass_3x3.sv @@
// ----------------------------------------------------------------------------
// laplacian_highpass_3x3
// Streaming 3x3 four-neighbour Laplacian high-pass filter on gray pixels.
// ----------------------------------------------------------------------------
// RGB pixels enter in raster order at one per clock while in_full is low and
// are reduced to gray, (R+G+B)/3. A simple dual-port line store of MAX_WIDTH x
// 16 bits keeps the two rows above, with one read and one write each cycle,
// which sets the rate of one pixel per clock. Each interior pixel yields one
// beat, clamped to 0..255, with its column, row and a flag on the last interior
// pixel of the image; the beat comes once the pixel below and to the right is
// taken. Border pixels give no beat. The line store needs no clearing after
// reset. Write image_width and image_height only while the filter is idle.
// ----------------------------------------------------------------------------
module laplacian_highpass_3x3 #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  lhp_pkg::in_beat_t                in_data,
  output logic                             in_full,
  output logic                             out_empty,
  input  logic                             out_pop,
  output lhp_pkg::out_beat_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lhp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lhp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [lhp_pkg::CFG_WIDTH_W-1:0]  width_r;
  logic [lhp_pkg::CFG_HEIGHT_W-1:0] height_r;

  logic                       job_push;
  lhp_pkg::lhp_job_t          job_in;
  logic                       job_pop;
  lhp_pkg::lhp_job_t          job_out;
  logic                       job_empty;
  logic [lhp_pkg::JOB_CW-1:0] job_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lhp_pkg::WIDTH_RESET;
      height_r <= lhp_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lhp_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[lhp_pkg::CFG_WIDTH_W-1:0];
        lhp_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data[lhp_pkg::CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  lhp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data      (in_data),
    .in_full      (in_full),
    .image_width  (width_r),
    .image_height (height_r),
    .job_count    (job_count),
    .job_push     (job_push),
    .job_data     (job_in)
  );

  lhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .pop_data  (job_out),
    .empty     (job_empty),
    .count     (job_count)
  );

  lhp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/lhp_queue.sv @@
// ----------------------------------------------------------------------------
// lhp_queue
// Short job queue between the window front end and the filter back end.
// ----------------------------------------------------------------------------
module lhp_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  lhp_pkg::lhp_job_t             push_data,
  input  logic                          pop,
  output lhp_pkg::lhp_job_t             pop_data,
  output logic                          empty,
  output logic [lhp_pkg::JOB_CW-1:0]    count
);

  lhp_pkg::lhp_job_t               slot_r [lhp_pkg::JOB_DEPTH];
  logic [lhp_pkg::JOB_AW-1:0]      wp_r;
  logic [lhp_pkg::JOB_AW-1:0]      rp_r;
  logic [lhp_pkg::JOB_CW-1:0]      cnt_r;
  logic                            do_pop;

  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;
  assign pop_data = slot_r[rp_r];
  assign do_pop   = pop & ~empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/lhp_front.sv @@
// ----------------------------------------------------------------------------
// lhp_front
// Pixel intake: gray conversion, raster counters, line store and window.
// ----------------------------------------------------------------------------
module lhp_front #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  lhp_pkg::in_beat_t                 in_data,
  output logic                              in_full,
  input  logic [lhp_pkg::CFG_WIDTH_W-1:0]   image_width,
  input  logic [lhp_pkg::CFG_HEIGHT_W-1:0]  image_height,
  input  logic [lhp_pkg::JOB_CW-1:0]        job_count,
  output logic                              job_push,
  output lhp_pkg::lhp_job_t                 job_data
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = (AW + 1 > lhp_pkg::CFG_WIDTH_W) ? AW + 1 : lhp_pkg::CFG_WIDTH_W;

  logic [15:0]   line_mem_r [MAX_WIDTH];
  logic [15:0]   rd_data_r;

  logic [AW-1:0] x_r;
  logic [15:0]   y_r;

  logic          b_vld_r;
  logic [AW-1:0] b_x_r;
  logic [7:0]    b_gray_r;
  logic          b_int_r;
  logic [10:0]   b_col_r;
  logic [15:0]   b_row_r;
  logic          b_last_r;

  logic          wr_vld_r;
  logic [AW-1:0] wr_addr_r;
  logic [15:0]   wr_data_r;

  logic [7:0]    west_r;
  logic [7:0]    prev_top_r;
  logic [7:0]    prev_mid_r;
  logic [7:0]    prev_bot_r;

  logic          accept;
  logic [9:0]    rgb_sum;
  logic [19:0]   rgb_prod;
  logic [7:0]    gray;
  logic [CW-1:0] w_eff;
  logic [CW-1:0] x_ext;
  logic [CW-1:0] x_inc;
  logic [16:0]   y_inc;
  logic          x_wrap;
  logic          y_wrap;
  logic          interior;
  logic          last_pix;
  logic [CW-1:0] col_full;
  logic [15:0]   entry;
  logic [7:0]    top;
  logic [7:0]    mid;

  assign in_full = (job_count + lhp_pkg::JOB_CW'(b_vld_r)) >= lhp_pkg::JOB_CW'(lhp_pkg::JOB_DEPTH);
  assign accept  = in_push & ~in_full;

  always_comb begin
    rgb_sum  = 10'(in_data.red) + 10'(in_data.green) + 10'(in_data.blue);
    rgb_prod = 20'(rgb_sum) * 20'(lhp_pkg::DIV3_MUL);
    gray     = rgb_prod[lhp_pkg::DIV3_SHIFT +: 8];

    w_eff    = (CW'(image_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(image_width);
    x_ext    = CW'(x_r);
    x_inc    = x_ext + CW'(1);
    y_inc    = 17'(y_r) + 17'd1;
    x_wrap   = (x_inc >= w_eff);
    y_wrap   = (y_inc >= 17'(image_height));
    interior = (x_ext >= CW'(2)) && (y_r >= 16'd2) && (x_ext < w_eff) && (y_r < image_height);
    last_pix = (x_inc == w_eff) && (y_inc == 17'(image_height));
    col_full = x_ext - CW'(1);
  end

  always_comb begin
    entry = (wr_vld_r && (wr_addr_r == b_x_r)) ? wr_data_r : rd_data_r;
    top   = entry[15:8];
    mid   = entry[7:0];

    job_push            = b_vld_r & b_int_r;
    job_data.centre     = prev_mid_r;
    job_data.north      = prev_top_r;
    job_data.south      = prev_bot_r;
    job_data.west       = west_r;
    job_data.east       = mid;
    job_data.column     = b_col_r;
    job_data.row        = b_row_r;
    job_data.last_pixel = b_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r        <= '0;
      y_r        <= '0;
      b_vld_r    <= 1'b0;
      wr_vld_r   <= 1'b0;
      west_r     <= '0;
      prev_top_r <= '0;
      prev_mid_r <= '0;
      prev_bot_r <= '0;
    end else begin
      b_vld_r <= accept;
      if (accept) begin
        if (x_wrap) begin
          x_r <= '0;
          y_r <= y_wrap ? 16'd0 : y_inc[15:0];
        end else begin
          x_r <= x_inc[AW-1:0];
        end
      end
      if (b_vld_r) begin
        wr_vld_r   <= 1'b1;
        west_r     <= prev_mid_r;
        prev_top_r <= top;
        prev_mid_r <= mid;
        prev_bot_r <= b_gray_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= line_mem_r[x_r];
      b_x_r     <= x_r;
      b_gray_r  <= gray;
      b_int_r   <= interior;
      b_col_r   <= col_full[10:0];
      b_row_r   <= y_r - 16'd1;
      b_last_r  <= last_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      line_mem_r[b_x_r] <= {mid, b_gray_r};
      wr_addr_r         <= b_x_r;
      wr_data_r         <= {mid, b_gray_r};
    end
  end

endmodule

@@ hw/rtl/lhp_back.sv @@
// ----------------------------------------------------------------------------
// lhp_back
// Laplacian kernel, clamp to 0..255 and the result output register.
// ----------------------------------------------------------------------------
module lhp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_empty,
  input  lhp_pkg::lhp_job_t     job_data,
  output logic                  job_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output lhp_pkg::out_beat_t    out_data
);

  logic                  out_vld_r;
  lhp_pkg::out_beat_t    out_data_r;
  logic [11:0]           lap;
  logic [7:0]            clamped;

  assign job_pop   = ~job_empty & (~out_vld_r | out_pop);
  assign out_empty = ~out_vld_r;
  assign out_data  = out_data_r;

  always_comb begin
    lap = {2'b00, job_data.centre, 2'b00}
        - 12'(job_data.north) - 12'(job_data.south)
        - 12'(job_data.west)  - 12'(job_data.east);
    if (lap[11]) begin
      clamped = 8'd0;
    end else if (|lap[10:8]) begin
      clamped = 8'hFF;
    end else begin
      clamped = lap[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (job_pop) begin
      out_vld_r <= 1'b1;
    end else if (out_pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      out_data_r.filtered   <= clamped;
      out_data_r.column     <= job_data.column;
      out_data_r.row        <= job_data.row;
      out_data_r.last_pixel <= job_data.last_pixel;
    end
  end

endmodule
